// File: rtl/core/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the RGB Sobel edge stream.
// ----------------------------------------------------------------------------
package sobel_pkg;

  localparam int MaxWidth  = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 16;
  localparam int WidthRegW = 11;
  localparam int HeightW   = 16;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  typedef logic [23:0] pix_t;

  // one classified window, passed from front to back
  typedef struct packed {
    pix_t [8:0] win;
    logic       last;
  } win_beat_t;

  // one finished result
  typedef struct packed {
    logic [7:0] mag_r;
    logic [7:0] mag_g;
    logic [7:0] mag_b;
    logic [7:0] vert_r;
    logic [7:0] vert_g;
    logic [7:0] vert_b;
    logic [7:0] horiz_r;
    logic [7:0] horiz_g;
    logic [7:0] horiz_b;
    logic       last;
  } res_beat_t;

endpackage

// File: rtl/core/sobel_front.sv
// ----------------------------------------------------------------------------
// sobel_front
// Line stores, 3x3 window and raster counters; emits interior windows.
// ----------------------------------------------------------------------------
module sobel_front
  import sobel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_idx,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 pix_vld,
  input  pix_t                 pix,
  output logic                 pix_rdy,
  output logic                 win_vld,
  output win_beat_t            win_beat,
  input  logic                 win_rdy
);

  logic [WidthRegW-1:0] width_r;
  logic [HeightW-1:0]   height_r;
  logic [ColW:0]        col_r, col_nxt, wlast;
  logic [HeightW-1:0]   row_r, row_nxt, hlast;
  logic                 busy_r;
  logic [ColW-1:0]      rd_col_r;
  logic                 emit_r, last_r;
  pix_t                 cur_r;
  pix_t                 upper_mem [MaxWidth];
  pix_t                 middle_mem[MaxWidth];
  pix_t                 top_q, mid_q;
  pix_t [8:0]           win_r;
  logic                 take;

  // effective frame size minus one
  always_comb begin
    if (width_r < WidthRegW'(3))
      wlast = (ColW+1)'(2);
    else if (width_r > WidthRegW'(MaxWidth))
      wlast = (ColW+1)'(MaxWidth - 1);
    else
      wlast = (ColW+1)'(width_r - WidthRegW'(1));
    hlast = (height_r < HeightW'(3)) ? HeightW'(2) : height_r - HeightW'(1);
  end

  // one pixel at a time: read stores, update window, hand the window to the back
  assign pix_rdy = !busy_r && !win_vld && win_rdy;
  assign take    = pix_vld && pix_rdy;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (col_r == wlast) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast) ? '0 : row_r + HeightW'(1);
      end else begin
        col_nxt = col_r + (ColW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WidthRegW'(640);
      height_r <= HeightW'(480);
      col_r    <= '0;
      row_r    <= '0;
      busy_r   <= 1'b0;
      win_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == RegWidth) begin
        width_r <= cfg_data[WidthRegW-1:0];
      end else begin
        height_r <= cfg_data;
      end
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      busy_r <= take;
      if (busy_r) begin
        win_r <= {cur_r, win_r[8:7], mid_q, win_r[5:4], top_q, win_r[2:1]};
      end
    end
  end

  // per-pixel payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      rd_col_r <= col_r[ColW-1:0];
      cur_r    <= pix;
      emit_r   <= (row_r >= HeightW'(2)) && (col_r >= (ColW+1)'(2));
      last_r   <= (row_r == hlast) && (col_r == wlast);
    end
  end

  // line stores: registered read, write-back of the shifted column
  always_ff @(posedge clk) begin
    if (take) begin
      top_q <= upper_mem[col_r[ColW-1:0]];
      mid_q <= middle_mem[col_r[ColW-1:0]];
    end
    if (busy_r) begin
      upper_mem[rd_col_r]  <= mid_q;
      middle_mem[rd_col_r] <= cur_r;
    end
  end

  // window beat valid the cycle after the window update
  logic emit_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) emit_d_r <= 1'b0;
    else        emit_d_r <= busy_r && emit_r && !cfg_we;
  end
  logic last_d_r;
  always_ff @(posedge clk) begin
    if (busy_r) last_d_r <= last_r;
  end

  assign win_vld       = emit_d_r;
  assign win_beat.win  = win_r;
  assign win_beat.last = last_d_r;

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast || $past(cfg_we)) else $error("column past width");
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !take) else $error("second pixel while busy");
  a_emit_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld |-> $past(busy_r)) else $error("window beat without pixel");
`endif

endmodule

// File: rtl/core/sobel_back.sv
// ----------------------------------------------------------------------------
// sobel_back
// Kernel sums, clamping and bit-serial integer square root per channel.
// ----------------------------------------------------------------------------
module sobel_back
  import sobel_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       win_vld,
  input  win_beat_t  win_beat,
  output logic       win_rdy,
  output logic       res_vld,
  output res_beat_t  res_beat,
  input  logic       res_rdy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROOT = 3'b010,
    S_DONE = 3'b100
  } st_t;

  st_t         st_r;
  logic [7:0]  v_r[3], h_r[3];
  logic [16:0] rem_r[3];
  logic [8:0]  root_r[3];
  logic [3:0]  step_r;
  logic        last_r;
  logic [7:0]  v_c[3], h_c[3];

  function automatic logic [7:0] clamp(input logic signed [11:0] x);
    if (x >= 12'sd255) return 8'd255;
    if (x <= 12'sd0)   return 8'd0;
    return x[7:0];
  endfunction

  // kernel sums per channel
  always_comb begin
    logic signed [11:0] t0, t1, t2, m0, m2, b0, b1, b2;
    for (int ch = 0; ch < 3; ch++) begin
      t0 = 12'(win_beat.win[0][16-8*ch +: 8]);
      t1 = 12'(win_beat.win[1][16-8*ch +: 8]);
      t2 = 12'(win_beat.win[2][16-8*ch +: 8]);
      m0 = 12'(win_beat.win[3][16-8*ch +: 8]);
      m2 = 12'(win_beat.win[5][16-8*ch +: 8]);
      b0 = 12'(win_beat.win[6][16-8*ch +: 8]);
      b1 = 12'(win_beat.win[7][16-8*ch +: 8]);
      b2 = 12'(win_beat.win[8][16-8*ch +: 8]);
      v_c[ch] = clamp((t0 + (t1 <<< 1) + t2) - (b0 + (b1 <<< 1) + b2));
      h_c[ch] = clamp((t0 + (m0 <<< 1) + b0) - (t2 + (m2 <<< 1) + b2));
    end
  end

  assign win_rdy = (st_r == S_IDLE);

  // restoring square root, one result bit per cycle, 9 steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (win_vld) begin
            for (int ch = 0; ch < 3; ch++) begin
              v_r[ch]    <= v_c[ch];
              h_r[ch]    <= h_c[ch];
              rem_r[ch]  <= 17'(v_c[ch]) * 17'(v_c[ch]) + 17'(h_c[ch]) * 17'(h_c[ch]);
              root_r[ch] <= '0;
            end
            last_r <= win_beat.last;
            step_r <= 4'd8;
            st_r   <= S_ROOT;
          end
        end
        S_ROOT: begin
          for (int ch = 0; ch < 3; ch++) begin
            logic [8:0]  trial;
            logic [17:0] sq;
            trial = root_r[ch] | (9'd1 << step_r);
            sq    = 18'(trial) * 18'(trial);
            if (sq <= 18'(rem_r[ch])) root_r[ch] <= trial;
          end
          if (step_r == 4'd0) st_r <= S_DONE;
          else step_r <= step_r - 4'd1;
        end
        S_DONE: begin
          if (res_rdy) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign res_vld = (st_r == S_DONE);
  assign res_beat.mag_r   = root_r[0][8] ? 8'd255 : root_r[0][7:0];
  assign res_beat.mag_g   = root_r[1][8] ? 8'd255 : root_r[1][7:0];
  assign res_beat.mag_b   = root_r[2][8] ? 8'd255 : root_r[2][7:0];
  assign res_beat.vert_r  = v_r[0];
  assign res_beat.vert_g  = v_r[1];
  assign res_beat.vert_b  = v_r[2];
  assign res_beat.horiz_r = h_r[0];
  assign res_beat.horiz_g = h_r[1];
  assign res_beat.horiz_b = h_r[2];
  assign res_beat.last    = last_r;

`ifndef SYNTH
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res_rdy |=> res_vld && $stable(root_r[0])) else $error("result moved");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld && win_rdy |=> st_r == S_ROOT) else $error("root not started");
`endif

endmodule

// File: rtl/core/sobel_fifo.sv
// ----------------------------------------------------------------------------
// sobel_fifo
// Small result queue feeding the output ports.
// ----------------------------------------------------------------------------
module sobel_fifo
  import sobel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_vld,
  input  res_beat_t wr_beat,
  output logic      wr_rdy,
  output logic      empty,
  output res_beat_t rd_beat,
  input  logic      pop
);

  res_beat_t      mem_r[QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic             wr, rd;

  assign wr_rdy  = cnt_r != (QPtrW+1)'(QDepth);
  assign empty   = cnt_r == '0;
  assign wr      = wr_vld && wr_rdy;
  assign rd      = pop && !empty;
  assign rd_beat = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + QPtrW'(1);
      if (rd) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_beat;
  end

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (QPtrW+1)'(QDepth)) |-> wp_r == rp_r)
    else $error("pointer mismatch");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
`endif

endmodule

// File: rtl/core/sobel_edge_rgb_stream.sv
// ----------------------------------------------------------------------------
// sobel_edge_rgb_stream
// RGB 3x3 Sobel edge detector: front keeps line stores and window, back
// computes clamped gradients and magnitude, a queue holds results.
// ----------------------------------------------------------------------------
//  channel  | handshake       | payload
//  in_      | push / full     | red, green, blue
//  out_     | pop / empty     | mag_*, vert_*, horiz_*, last_of_frame
//  cfg_     | we (no wait)    | idx, data
//
//  In the front a pixel passes a line store read, then a window shift.
//  An interior pixel then holds the back through sum/clamp, 9 root steps
//  and hand-off; the serial square root sets the sustained rate.
//  Reset is synchronous; line stores need no clearing.
//  Either side stalls on its own through the result queue.
// ----------------------------------------------------------------------------
module sobel_edge_rgb_stream
  import sobel_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_mag_red,
  output logic [7:0]          out_mag_green,
  output logic [7:0]          out_mag_blue,
  output logic [7:0]          out_vert_red,
  output logic [7:0]          out_vert_green,
  output logic [7:0]          out_vert_blue,
  output logic [7:0]          out_horiz_red,
  output logic [7:0]          out_horiz_green,
  output logic [7:0]          out_horiz_blue,
  output logic                out_last_of_frame
);

  logic      pix_rdy, win_vld, win_rdy, res_vld, res_rdy;
  win_beat_t win_beat;
  res_beat_t res_beat, q_beat;
  logic      back_rdy;

  // front waits until the back can take a window
  assign win_rdy = back_rdy;
  assign in_full = !pix_rdy;

  sobel_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .pix_vld (in_push),
    .pix     ({in_red, in_green, in_blue}),
    .pix_rdy (pix_rdy),
    .win_vld (win_vld),
    .win_beat(win_beat),
    .win_rdy (win_rdy)
  );

  sobel_back u_back (
    .clk, .rst_n,
    .win_vld (win_vld),
    .win_beat(win_beat),
    .win_rdy (back_rdy),
    .res_vld (res_vld),
    .res_beat(res_beat),
    .res_rdy (res_rdy)
  );

  sobel_fifo u_fifo (
    .clk, .rst_n,
    .wr_vld (res_vld),
    .wr_beat(res_beat),
    .wr_rdy (res_rdy),
    .empty  (out_empty),
    .rd_beat(q_beat),
    .pop    (out_pop)
  );

  assign out_mag_red       = q_beat.mag_r;
  assign out_mag_green     = q_beat.mag_g;
  assign out_mag_blue      = q_beat.mag_b;
  assign out_vert_red      = q_beat.vert_r;
  assign out_vert_green    = q_beat.vert_g;
  assign out_vert_blue     = q_beat.vert_b;
  assign out_horiz_red     = q_beat.horiz_r;
  assign out_horiz_green   = q_beat.horiz_g;
  assign out_horiz_blue    = q_beat.horiz_b;
  assign out_last_of_frame = q_beat.last;

`ifndef SYNTH
  a_no_lost_win: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld |-> win_rdy) else $error("window beat dropped");
  a_full_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !back_rdy |-> in_full) else $error("pixel taken while back busy");
  a_win_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld |-> $past(in_push && !in_full, 2))
    else $error("window beat without accepted pixel");
`endif

endmodule
